// ===== src/ppmfg_pkg.sv =====
`timescale 1ns / 1ps
// Package of the PPM frame generator: payload and configuration types,
// register map codes and reset constants. Depends on nothing.
package ppmfg_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_ENABLE      = 3'd0,
    REG_INVERT      = 3'd1,
    REG_CHANNELS    = 3'd2,
    REG_PULSE_LEN   = 3'd3,
    REG_FRAME_LEN   = 3'd4
  } reg_idx_t;

  // Item actions.
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic [15:0] DEFAULT_WIDTH_US   = 16'd1100;
  localparam logic        RST_ENABLE         = 1'b1;
  localparam logic        RST_INVERT         = 1'b0;
  localparam logic [4:0]  RST_CHANNEL_COUNT  = 5'd8;
  localparam logic [15:0] RST_PULSE_LEN_US   = 16'd300;
  localparam logic [15:0] RST_FRAME_LEN_US   = 16'd22500;

  typedef struct packed {
    logic        action;
    logic [3:0]  channel_index;
    logic [15:0] channel_width_us;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic phase_changed;
    logic frame_started;
    logic frame_led;
  } result_t;

  typedef struct packed {
    logic        enable_output;
    logic        invert_levels;
    logic [4:0]  channel_count;
    logic [15:0] pulse_length_us;
    logic [15:0] frame_length_us;
    logic        restart;
  } cfg_t;

endpackage

// ===== src/ppmfg_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the PPM frame generator items and
// results. Field widths follow the types in ppmfg_pkg.
interface ppmfg_item_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  channel_index;
  logic [15:0] channel_width_us;

  modport source (output valid, action, channel_index, channel_width_us, input ready);
  modport sink   (input valid, action, channel_index, channel_width_us, output ready);
endinterface

interface ppmfg_result_if;
  logic valid;
  logic ready;
  logic line_level;
  logic phase_changed;
  logic frame_started;
  logic frame_led;

  modport source (output valid, line_level, phase_changed, frame_started, frame_led,
                  input ready);
  modport sink   (input valid, line_level, phase_changed, frame_started, frame_led,
                  output ready);
endinterface

// ===== src/ppmfg_regs.sv =====
`timescale 1ns / 1ps
// APB-style configuration registers of the PPM frame generator.
// Depends on ppmfg_pkg.
module ppmfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppmfg_pkg::ADDR_W-1:0] paddr,
  input  logic [ppmfg_pkg::DATA_W-1:0] pwdata,
  output logic [ppmfg_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output ppmfg_pkg::cfg_t              cfg
);
  import ppmfg_pkg::*;

  logic        enable_output;
  logic        invert_levels;
  logic [4:0]  channel_count;
  logic [15:0] pulse_length_us;
  logic [15:0] frame_length_us;
  logic        wr;
  reg_idx_t    reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_output   <= RST_ENABLE;
      invert_levels   <= RST_INVERT;
      channel_count   <= RST_CHANNEL_COUNT;
      pulse_length_us <= RST_PULSE_LEN_US;
      frame_length_us <= RST_FRAME_LEN_US;
    end else if (wr) begin
      unique case (reg_sel)
        REG_ENABLE:    enable_output   <= pwdata[0];
        REG_INVERT:    invert_levels   <= pwdata[0];
        REG_CHANNELS:  channel_count   <= pwdata[4:0];
        REG_PULSE_LEN: pulse_length_us <= pwdata[15:0];
        REG_FRAME_LEN: frame_length_us <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ENABLE:    prdata = {{(DATA_W-1){1'b0}}, enable_output};
      REG_INVERT:    prdata = {{(DATA_W-1){1'b0}}, invert_levels};
      REG_CHANNELS:  prdata = {{(DATA_W-5){1'b0}}, channel_count};
      REG_PULSE_LEN: prdata = {{(DATA_W-16){1'b0}}, pulse_length_us};
      REG_FRAME_LEN: prdata = {{(DATA_W-16){1'b0}}, frame_length_us};
      default:       prdata = '0;
    endcase
  end

  // Enabling a stopped generator restarts the frame at the same edge.
  always_comb begin
    cfg.enable_output   = enable_output;
    cfg.invert_levels   = invert_levels;
    cfg.channel_count   = channel_count;
    cfg.pulse_length_us = pulse_length_us;
    cfg.frame_length_us = frame_length_us;
    cfg.restart         = wr && (reg_sel == REG_ENABLE) && pwdata[0] && !enable_output;
  end

endmodule

// ===== src/ppmfg_core.sv =====
`timescale 1ns / 1ps
// Frame state and single-pass step logic of the PPM frame generator: time
// counter, deadline, channel sequencing and width table. Depends on ppmfg_pkg.
module ppmfg_core #(
  parameter int MAX_CHANNELS = 16,
  parameter int TIME_BITS    = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  ppmfg_pkg::cfg_t    cfg,
  input  logic               step,
  input  ppmfg_pkg::item_t   item,
  output ppmfg_pkg::result_t result
);
  import ppmfg_pkg::*;

  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [TIME_BITS-1:0] time_now;
  logic [TIME_BITS-1:0] deadline;
  logic [TIME_BITS-1:0] frame_start_time;
  logic [CNT_W-1:0]     current_channel;
  logic                 in_space;
  logic                 line_state;
  logic                 led_state;
  logic [15:0]          channel_widths [MAX_CHANNELS];

  logic [TIME_BITS-1:0] time_now_next;
  logic [TIME_BITS-1:0] deadline_next;
  logic [TIME_BITS-1:0] frame_start_time_next;
  logic [CNT_W-1:0]     current_channel_next;
  logic                 in_space_next;
  logic                 line_state_next;
  logic                 led_state_next;

  logic [TIME_BITS-1:0] since_deadline;
  logic [TIME_BITS-1:0] sync_end;
  logic [TIME_BITS-1:0] start_time;
  logic [15:0]          width_sel;
  logic                 is_tick;
  logic                 fire;
  logic                 first;
  logic                 more;
  logic                 wr_ok;

  assign is_tick        = (item.action == ACT_TICK);
  assign time_now_next  = time_now + TIME_BITS'(1);
  assign since_deadline = time_now_next - deadline;
  // Wrap-aware compare: reached when the difference is in the lower half.
  assign fire           = is_tick && cfg.enable_output && !since_deadline[TIME_BITS-1];
  assign first          = (current_channel == '0);
  assign start_time     = first ? time_now_next : frame_start_time;
  assign more           = (32'(current_channel) < 32'(cfg.channel_count))
                       && (32'(current_channel) < MAX_CHANNELS);
  assign width_sel      = channel_widths[current_channel[IDX_W-1:0]];
  assign sync_end       = start_time + TIME_BITS'(cfg.frame_length_us)
                        - TIME_BITS'(cfg.pulse_length_us);
  assign wr_ok          = !is_tick && (32'(item.channel_index) < MAX_CHANNELS);

  always_comb begin
    deadline_next         = deadline;
    frame_start_time_next = frame_start_time;
    current_channel_next  = current_channel;
    in_space_next         = in_space;
    line_state_next       = line_state;
    led_state_next        = led_state;
    if (fire) begin
      in_space_next = !in_space;
      if (in_space) begin
        deadline_next   = time_now_next + TIME_BITS'(cfg.pulse_length_us);
        line_state_next = 1'b0;
      end else begin
        line_state_next = 1'b1;
        if (first) begin
          frame_start_time_next = time_now_next;
          led_state_next        = !led_state;
        end
        if (more) begin
          deadline_next        = time_now_next + TIME_BITS'(width_sel);
          current_channel_next = current_channel + CNT_W'(1);
        end else begin
          deadline_next        = sync_end;
          current_channel_next = '0;
        end
      end
    end
  end

  always_comb begin
    result.line_level    = line_state_next ^ cfg.invert_levels;
    result.phase_changed = fire;
    result.frame_started = fire && !in_space && first;
    result.frame_led     = led_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now         <= '0;
      deadline         <= '0;
      frame_start_time <= '0;
      current_channel  <= '0;
      in_space         <= 1'b0;
      line_state       <= 1'b0;
      led_state        <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        channel_widths[i] <= DEFAULT_WIDTH_US;
      end
    end else begin
      if (step && is_tick) begin
        time_now <= time_now_next;
      end
      if (cfg.restart) begin
        in_space         <= 1'b0;
        current_channel  <= '0;
        frame_start_time <= '0;
        deadline         <= time_now;
        line_state       <= 1'b0;
      end else if (step) begin
        deadline         <= deadline_next;
        frame_start_time <= frame_start_time_next;
        current_channel  <= current_channel_next;
        in_space         <= in_space_next;
        line_state       <= line_state_next;
        led_state        <= led_state_next;
      end
      if (step && wr_ok) begin
        channel_widths[IDX_W'(item.channel_index)] <= item.channel_width_us;
      end
    end
  end

endmodule

// ===== src/ppm_frame_generator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the PPM frame generator: input and result registers around
// the step logic. Depends on ppmfg_pkg, ppmfg_if, ppmfg_regs and ppmfg_core.
//
// Usage. Items arrive on the item channel (valid/ready). Each item is either
// a one-microsecond tick (action 0) or a write of one channel's width
// (action 1). Every item gives exactly one transfer on the result channel,
// carrying the line level, whether the phase toggled, whether a frame began
// and the frame indicator level.
// An accepted item waits in the input register; once the result register is
// free or being emptied, the step logic updates the frame state and loads
// the result register, from which the result is transferred.
// Throughput is one item per cycle while the receiver takes every result.
// The input register accepts a new item while a result waits, so the two
// channels are decoupled by one stage each.
// When the receiver stalls, the result register holds its transfer, the
// input register fills, and ready on the item channel drops until the
// result is taken. No item or result is lost while stalled.
// Configuration is to be written over the APB-style port only while no item
// is in flight; the block does not enforce this. Writing 1 to enable_output
// while it is 0 restarts the frame, so the next tick starts channel zero.
// Synchronous reset empties both registers, sets every channel width to
// 1100 us, clears the time counter and loads the default register values;
// the block accepts items from the first cycle after reset.
module ppm_frame_generator_unit #(
  parameter int MAX_CHANNELS = 16,
  parameter int TIME_BITS    = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  ppmfg_item_if.sink                   item,
  ppmfg_result_if.source               result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppmfg_pkg::ADDR_W-1:0] paddr,
  input  logic [ppmfg_pkg::DATA_W-1:0] pwdata,
  output logic [ppmfg_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);
  import ppmfg_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_valid;
  result_t res_q;
  result_t core_res;
  logic    res_valid;
  logic    step;

  // The configuration registers sit apart from the data path.
  ppmfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held item is processed whenever the result register is free or is
  // being emptied in this cycle.
  assign step       = in_valid && (!res_valid || result.ready);
  assign item.ready = !in_valid || step;

  ppmfg_core #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .TIME_BITS    (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .item   (in_q),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (item.ready) begin
        in_valid <= item.valid;
      end
      if (step) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_q.action           <= item.action;
      in_q.channel_index    <= item.channel_index;
      in_q.channel_width_us <= item.channel_width_us;
    end
    if (step) begin
      res_q <= core_res;
    end
  end

  assign result.valid         = res_valid;
  assign result.line_level    = res_q.line_level;
  assign result.phase_changed = res_q.phase_changed;
  assign result.frame_started = res_q.frame_started;
  assign result.frame_led     = res_q.frame_led;

`ifndef SYNTHESIS
  // A width write never toggles the phase.
  a_write_no_phase: assert property (@(posedge clk) disable iff (rst)
    (step && (in_q.action == ACT_WRITE)) |=> !res_q.phase_changed)
    else $error("width write produced a phase change");

  // A frame only starts on a phase change.
  a_start_on_change: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.frame_started) |-> res_q.phase_changed)
    else $error("frame start without phase change");

  // A held item that is not processed stays in the input register.
  a_item_kept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !step) |=> in_valid)
    else $error("held item dropped");

  // The frame indicator toggles exactly when a frame starts.
  a_led_toggle: assert property (@(posedge clk) disable iff (rst)
    step |-> ((core_res.frame_led != u_core.led_state) == core_res.frame_started))
    else $error("frame indicator inconsistent");
`endif

endmodule

// ===== tb/sv/ppmfg_frame_check_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the PPM frame generator: a cycle-free model of the frame state
// and a queue of awaited output transfers. Depends on ppmfg_pkg.
package ppmfg_frame_check_pkg;
  import ppmfg_pkg::*;

  localparam int CHANNEL_SLOTS = 16;

  class ppm_frame_scoreboard;
    // Register copies.
    logic        enable;
    logic        invert;
    logic [4:0]  count;
    logic [15:0] pulse_len;
    logic [15:0] frame_len;
    // Frame state.
    logic [31:0] now_us;
    logic [31:0] deadline_us;
    logic [31:0] frame_start_us;
    logic [4:0]  channel;
    logic        in_space;
    logic        line_on;
    logic        led;
    logic [15:0] widths [CHANNEL_SLOTS];
    result_t     awaited_outputs [$];
    int unsigned failures;

    function new();
      enable         = RST_ENABLE;
      invert         = RST_INVERT;
      count          = RST_CHANNEL_COUNT;
      pulse_len      = RST_PULSE_LEN_US;
      frame_len      = RST_FRAME_LEN_US;
      now_us         = '0;
      deadline_us    = '0;
      frame_start_us = '0;
      channel        = '0;
      in_space       = 1'b0;
      line_on        = 1'b0;
      led            = 1'b0;
      failures       = 0;
      foreach (widths[i]) widths[i] = DEFAULT_WIDTH_US;
    endfunction

    function int pending();
      return awaited_outputs.size();
    endfunction

    function void set_register(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_ENABLE: begin
          // Switching the generator back on starts a fresh frame at once.
          if (value[0] && !enable) begin
            in_space       = 1'b0;
            channel        = '0;
            frame_start_us = '0;
            deadline_us    = now_us;
            line_on        = 1'b0;
          end
          enable = value[0];
        end
        REG_INVERT:    invert    = value[0];
        REG_CHANNELS:  count     = value[4:0];
        REG_PULSE_LEN: pulse_len = value[15:0];
        REG_FRAME_LEN: frame_len = value[15:0];
        default: ;
      endcase
    endfunction

    function void accept_item(item_t it);
      result_t     r;
      logic [31:0] gap;
      logic [4:0]  used;
      logic        changed;
      logic        started;
      changed = 1'b0;
      started = 1'b0;
      if (it.action == ACT_WRITE) begin
        widths[it.channel_index] = it.channel_width_us;
      end else begin
        now_us = now_us + 32'd1;
        gap    = now_us - deadline_us;
        // The deadline counts as reached when it lies in the past half of the time circle.
        if (enable && !gap[31]) begin
          changed = 1'b1;
          if (in_space) begin
            deadline_us = now_us + 32'(pulse_len);
            line_on     = 1'b0;
          end else begin
            used = (count > 5'(CHANNEL_SLOTS)) ? 5'(CHANNEL_SLOTS) : count;
            if (channel == 5'd0) begin
              frame_start_us = now_us;
              led            = ~led;
              started        = 1'b1;
            end
            if (channel < used) begin
              deadline_us = now_us + 32'(widths[channel[3:0]]);
              channel     = channel + 5'd1;
            end else begin
              deadline_us = frame_start_us + 32'(frame_len) - 32'(pulse_len);
              channel     = '0;
            end
            line_on = 1'b1;
          end
          in_space = ~in_space;
        end
      end
      r.line_level    = line_on ^ invert;
      r.phase_changed = changed;
      r.frame_started = started;
      r.frame_led     = led;
      awaited_outputs.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_outputs.size() == 0) begin
        $error("result transfer arrived with nothing awaited");
        failures++;
        return;
      end
      want = awaited_outputs.pop_front();
      if (got.line_level !== want.line_level) begin
        $error("line_level: expected %0b, actual %0b", want.line_level, got.line_level);
        failures++;
      end
      if (got.phase_changed !== want.phase_changed) begin
        $error("phase_changed: expected %0b, actual %0b", want.phase_changed, got.phase_changed);
        failures++;
      end
      if (got.frame_started !== want.frame_started) begin
        $error("frame_started: expected %0b, actual %0b", want.frame_started, got.frame_started);
        failures++;
      end
      if (got.frame_led !== want.frame_led) begin
        $error("frame_led: expected %0b, actual %0b", want.frame_led, got.frame_led);
        failures++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/ppm_frame_generator_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking test of ppm_frame_generator_unit: random and directed ticks and
// width writes under several register settings. Depends on ppmfg_pkg, ppmfg_if,
// ppmfg_frame_check_pkg and the RTL of the block.
module ppm_frame_generator_unit_test;
  import ppmfg_pkg::*;
  import ppmfg_frame_check_pkg::*;

  // A run with nothing accepted for this many cycles is taken as hung. The
  // longest legitimate quiet stretch is the deliberate receiver hold-off.
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic        pready;

  ppmfg_item_if   item_bus ();
  ppmfg_result_if result_bus ();

  ppm_frame_generator_unit dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ppm_frame_scoreboard tracker = new();

  // Percentages of cycles in which each side holds back, changed per phase.
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  // Set by the main sequence to ask the receiver for a long hold-off.
  int          hold_request = 0;
  int          quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offers one item, idling beforehand at the current sender rate, and returns
  // at the edge on which the transfer took place. Valid is left high so that
  // back-to-back items never drop it in between.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid            <= 1'b1;
    item_bus.action           <= it.action;
    item_bus.channel_index    <= it.channel_index;
    item_bus.channel_width_us <= it.channel_width_us;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    tracker.accept_item(it);
  endtask

  // One APB write: a setup cycle, then the access cycle, which completes at
  // the edge where pready is seen high. A spare cycle follows so that psel is
  // never lowered and raised at the same edge by two writes in a row.
  task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Writes every register. With a restart requested, the generator is first
  // switched off so that the final enable write begins a fresh frame; this
  // also clears any deadline left far in the future by a long width.
  task automatic apply_settings(input logic en, input logic inv, input logic [4:0] cnt,
                                input logic [15:0] pulse, input logic [15:0] frame,
                                input bit restart_frame);
    if (restart_frame) apb_write(REG_ENABLE, 32'd0);
    apb_write(REG_INVERT,    32'(inv));
    apb_write(REG_CHANNELS,  32'(cnt));
    apb_write(REG_PULSE_LEN, 32'(pulse));
    apb_write(REG_FRAME_LEN, 32'(frame));
    apb_write(REG_ENABLE,    32'(en));
  endtask

  // Stops offering items and waits until every awaited result has been
  // taken, with a short margin for the two-stage pipeline.
  task automatic settle();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly ticks with short widths written now and then, so that frames run
  // through many channels. A width from the full range turns up only rarely,
  // as it can stall a frame for tens of thousands of ticks.
  task automatic run_random(input int n, input int unsigned write_pct);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it.action        = ($urandom_range(99) < write_pct) ? ACT_WRITE : ACT_TICK;
      it.channel_index = 4'($urandom_range(15));
      if ($urandom_range(49) == 0) it.channel_width_us = 16'($urandom);
      else it.channel_width_us = 16'($urandom_range(40));
      send_item(it);
    end
  endtask

  task automatic send_tick();
    item_t it;
    it.action           = ACT_TICK;
    it.channel_index    = 4'($urandom_range(15));
    it.channel_width_us = 16'($urandom);
    send_item(it);
  endtask

  task automatic send_width(input logic [3:0] idx, input logic [15:0] width);
    item_t it;
    it.action           = ACT_WRITE;
    it.channel_index    = idx;
    it.channel_width_us = width;
    send_item(it);
  endtask

  // Result side: checks every transfer against the oldest expectation and
  // sets ready for the next cycle, either from the idle rate or from a long
  // hold-off counted here.
  initial begin
    result_t got;
    int      hold_left;
    hold_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_bus.valid && result_bus.ready) begin
        got.line_level    = result_bus.line_level;
        got.phase_changed = result_bus.phase_changed;
        got.frame_started = result_bus.frame_started;
        got.frame_led     = result_bus.frame_led;
        tracker.check_result(got);
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel makes a transfer.
  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst                       <= 1'b1;
    item_bus.valid            <= 1'b0;
    item_bus.action           <= ACT_TICK;
    item_bus.channel_index    <= '0;
    item_bus.channel_width_us <= '0;
    psel                      <= 1'b0;
    penable                   <= 1'b0;
    pwrite                    <= 1'b0;
    paddr                     <= '0;
    pwdata                    <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Two ticks under the reset settings: the first one
    // reaches the zero deadline at once and opens a frame.
    send_tick();
    send_tick();
    settle();
    // A short frame of two channels. The width writes cover both extremes of
    // the width and index fields; a write to channel 15 is outside the frame
    // but must still be stored.
    apply_settings(1'b1, 1'b0, 5'd2, 16'd1, 16'd12, 1'b1);
    send_width(4'd0, 16'd3);
    send_width(4'd15, 16'hFFFF);
    send_width(4'd1, 16'd0);
    send_width(4'd15, 16'h0000);
    send_width(4'd2, 16'd5);
    // Enough ticks to go through both marks, the sync gap and into a second
    // frame, so the indicator toggles twice.
    repeat (16) send_tick();
    settle();

    // Random part, first with a slow receiver.
    src_idle_pct = 14;
    snk_idle_pct = 88;
    apply_settings(1'b1, 1'b0, 5'd4, 16'd3, 16'd60, 1'b1);
    run_random(230, 15);
    settle();
    // Output switched off: time keeps running but line and phase are frozen,
    // while the inverted levels show at once.
    apply_settings(1'b0, 1'b1, 5'd16, 16'd2, 16'd100, 1'b0);
    run_random(120, 15);
    settle();
    // Switching back on restarts the frame without an explicit restart.
    apply_settings(1'b1, 1'b1, 5'd16, 16'd1, 16'd200, 1'b0);
    run_random(230, 15);
    settle();

    // Slow sender, eager receiver.
    src_idle_pct = 88;
    snk_idle_pct = 14;
    // No channels and zero lengths: every mark is a sync mark whose end is
    // already due, so the phase toggles on every tick.
    apply_settings(1'b1, 1'b0, 5'd0, 16'd0, 16'd0, 1'b1);
    run_random(200, 15);
    settle();
    // Largest lengths and a channel count beyond the channel store.
    apply_settings(1'b1, 1'b0, 5'd31, 16'hFFFF, 16'hFFFF, 1'b0);
    run_random(120, 15);
    settle();
    apply_settings(1'b1, 1'b1, 5'd1, 16'd5, 16'd30, 1'b1);
    run_random(230, 15);
    settle();

    // No idling on either side.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    // A zero frame length puts the sync end in the past; it must fire on the
    // following tick. The receiver holds off for a long stretch here, so the
    // pipeline fills and the item channel stalls.
    apply_settings(1'b1, 1'b0, 5'd8, 16'd2, 16'd0, 1'b1);
    hold_request = HOLD_CYCLES;
    run_random(250, 15);
    settle();
    // Seventeen channels are clamped to sixteen; the sender pauses mid-phase
    // until every result is in.
    apply_settings(1'b1, 1'b1, 5'd17, 16'd4, 16'd120, 1'b0);
    run_random(120, 15);
    settle();
    run_random(120, 15);
    settle();
    apply_settings(1'b1, 1'b0, 5'd16, 16'd1, 16'd400, 1'b1);
    run_random(350, 15);
    settle();

    // Allow any stray transfer to show up before the verdict.
    repeat (10) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ppmfg_pkg.sv
src/ppmfg_if.sv
src/ppmfg_regs.sv
src/ppmfg_core.sv
src/ppm_frame_generator_unit.sv
tb/sv/ppmfg_frame_check_pkg.sv
tb/sv/ppm_frame_generator_unit_test.sv
